@@ rtl/hab_pkg.sv @@
// shared constants and helpers for the hex and base-11 line formatter
package hab_pkg;

    // input field width and the masking width applied to it
    localparam int VALUE_W    = 31;
    localparam int VALUE_BITS = 31;
    localparam logic [VALUE_W-1:0] VALUE_MASK = VALUE_W'((64'd1 << VALUE_BITS) - 64'd1);

    // stream widths, padded to whole bytes
    localparam int S_TDATA_W = ((VALUE_W + 7) / 8) * 8;
    localparam int CHAR_W    = 7;
    localparam int M_TDATA_W = ((CHAR_W + 7) / 8) * 8;

    // hex digits that cover the input field
    localparam int HEX_DIGITS = (VALUE_W + 3) / 4;
    localparam int HEX_POS_W  = $clog2(HEX_DIGITS);
    localparam int HEX_EXT_W  = HEX_DIGITS * 4;

    // base-11 digit store
    localparam int STORE_DEPTH = 9;
    localparam int CNT_W       = $clog2(STORE_DEPTH + 1);

    // divide by 11 as multiply by ceil(2^35 / 11) and shift by 35
    localparam int                  RECIP_W   = 32;
    localparam logic [RECIP_W-1:0]  B11_RECIP = 32'hBA2E8BA3;
    localparam int                  B11_SHIFT = 35;
    localparam int                  PROD_W    = VALUE_W + RECIP_W;
    localparam int                  QUOT_W    = PROD_W - B11_SHIFT;

    // ascii codes
    localparam logic [CHAR_W-1:0] ASCII_ZERO  = 7'd48;
    localparam logic [CHAR_W-1:0] ASCII_ALPHA = 7'd55;  // 'A' minus ten
    localparam logic [CHAR_W-1:0] ASCII_SPACE = 7'd32;
    localparam logic [CHAR_W-1:0] ASCII_NL    = 7'd10;
    localparam logic [3:0]        DEC_LIMIT   = 4'd10;

    function automatic logic [CHAR_W-1:0] digit_char(input logic [3:0] d);
        if (d < DEC_LIMIT) begin
            return ASCII_ZERO + CHAR_W'(d);
        end else begin
            return ASCII_ALPHA + CHAR_W'(d);
        end
    endfunction

endpackage

@@ rtl/hex_and_base11_formatter.sv @@
// hex and base-11 ascii line formatter, one line per input beat
//
//  channel | dir | fields (tdata low bit up)       | marker
//  --------+-----+---------------------------------+-------------------------
//  s_      | in  | value[30:0], pad                | none
//  m_      | out | char_code[6:0], pad             | tlast on the newline
//
//  with no output stall, the base-11 digits come from one shared 31x32
//  reciprocal multiplier, which multiplies and then corrects and stores
//  each digit (up to nine digits), running while the hex digits and the
//  space leave at one character a cycle; base-11 digits and the newline
//  follow one a cycle
//  s_tready is high only while idle; a new value is taken once the newline
//  sits in the output register
//  aresetn is synchronous and active low; it clears the sequencer and the
//  output valid, the digit store needs no reset
//  a low m_tready holds the output register and stalls the sequencer, the
//  divider keeps going until its digits are all stored
module hex_and_base11_formatter (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [hab_pkg::S_TDATA_W-1:0]   s_tdata,   // value[30:0], zero pad
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [hab_pkg::M_TDATA_W-1:0]   m_tdata,   // char_code[6:0], zero pad
    output logic                            m_tlast    // last_char
);
    import hab_pkg::*;

    typedef enum logic [2:0] {S_IDLE, S_HEX, S_SPACE, S_B11, S_NL} state_t;

    state_t                 state_reg, state_next;
    logic [VALUE_W-1:0]     hex_reg, hex_next;
    logic [HEX_POS_W-1:0]   hex_pos_reg, hex_pos_next;
    logic [VALUE_W-1:0]     work_reg, work_next;
    logic [PROD_W-1:0]      prod_reg, prod_next;
    logic                   div_busy_reg, div_busy_next;
    logic                   div_mul_reg, div_mul_next;  // high: product ready
    logic [CNT_W-1:0]       cnt_reg, cnt_next;
    logic [CNT_W-1:0]       rd_reg, rd_next;
    logic                   m_valid_reg, m_valid_next;
    logic [CHAR_W-1:0]      m_char_reg, m_char_next;
    logic                   m_last_reg, m_last_next;

    logic [3:0]             store_mem [STORE_DEPTH];

    logic                   accept;
    logic                   slot_free;
    logic [VALUE_W-1:0]     in_value;
    logic [HEX_EXT_W-1:0]   in_ext;
    logic [HEX_POS_W-1:0]   lead_pos;
    logic [HEX_EXT_W-1:0]   hex_ext;
    logic [3:0]             hex_nib;
    logic [QUOT_W-1:0]      quot;
    logic [VALUE_W-1:0]     quot11;
    logic [VALUE_W-1:0]     rem_full;
    logic [3:0]             rem;
    logic                   store_we;

    assign s_tready  = (state_reg == S_IDLE);
    assign accept    = s_tvalid && s_tready;
    assign slot_free = !m_valid_reg || m_tready;

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = M_TDATA_W'(m_char_reg);
    assign m_tlast  = m_last_reg;

    // most significant nonzero nibble of the incoming value
    assign in_value = s_tdata[VALUE_W-1:0] & VALUE_MASK;
    assign in_ext   = HEX_EXT_W'(in_value);

    always_comb begin
        lead_pos = '0;
        for (int i = 0; i < HEX_DIGITS; i++) begin
            if (in_ext[i*4 +: 4] != 4'd0) begin
                lead_pos = HEX_POS_W'(i);
            end
        end
    end

    assign hex_ext = HEX_EXT_W'(hex_reg);
    assign hex_nib = hex_ext[{hex_pos_reg, 2'b00} +: 4];

    // quotient and remainder from the registered product
    assign quot     = prod_reg[PROD_W-1:B11_SHIFT];
    assign quot11   = VALUE_W'({quot, 3'b000}) + VALUE_W'({quot, 1'b0}) + VALUE_W'(quot);
    assign rem_full = work_reg - quot11;
    assign rem      = rem_full[3:0];
    assign store_we = div_busy_reg && div_mul_reg;

    always_comb begin
        state_next    = state_reg;
        hex_next      = hex_reg;
        hex_pos_next  = hex_pos_reg;
        work_next     = work_reg;
        prod_next     = prod_reg;
        div_busy_next = div_busy_reg;
        div_mul_next  = div_mul_reg;
        cnt_next      = cnt_reg;
        rd_next       = rd_reg;
        m_valid_next  = m_valid_reg && !m_tready;
        m_char_next   = m_char_reg;
        m_last_next   = m_last_reg;

        // shared divide-by-11 unit: multiply, then correct and store
        if (div_busy_reg) begin
            div_mul_next = !div_mul_reg;
            if (!div_mul_reg) begin
                prod_next = PROD_W'(work_reg) * PROD_W'(B11_RECIP);
            end else begin
                work_next = VALUE_W'(quot);
                cnt_next  = cnt_reg + 1'b1;
                if (quot == '0) begin
                    div_busy_next = 1'b0;
                    rd_next       = cnt_reg;
                end
            end
        end

        unique case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    hex_next      = in_value;
                    hex_pos_next  = lead_pos;
                    work_next     = in_value;
                    cnt_next      = '0;
                    div_busy_next = 1'b1;
                    div_mul_next  = 1'b0;
                    state_next    = S_HEX;
                end
            end
            S_HEX: begin
                if (slot_free) begin
                    m_valid_next = 1'b1;
                    m_char_next  = digit_char(hex_nib);
                    m_last_next  = 1'b0;
                    if (hex_pos_reg == '0) begin
                        state_next = S_SPACE;
                    end else begin
                        hex_pos_next = hex_pos_reg - 1'b1;
                    end
                end
            end
            S_SPACE: begin
                if (slot_free) begin
                    m_valid_next = 1'b1;
                    m_char_next  = ASCII_SPACE;
                    m_last_next  = 1'b0;
                    state_next   = S_B11;
                end
            end
            S_B11: begin
                // wait for the last quotient, then send digits from the top
                if (slot_free && !div_busy_reg) begin
                    m_valid_next = 1'b1;
                    m_char_next  = digit_char(store_mem[rd_reg]);
                    m_last_next  = 1'b0;
                    if (rd_reg == '0) begin
                        state_next = S_NL;
                    end else begin
                        rd_next = rd_reg - 1'b1;
                    end
                end
            end
            S_NL: begin
                if (slot_free) begin
                    m_valid_next = 1'b1;
                    m_char_next  = ASCII_NL;
                    m_last_next  = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            div_busy_reg <= 1'b0;
            div_mul_reg  <= 1'b0;
            cnt_reg      <= '0;
            rd_reg       <= '0;
            work_reg     <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            div_busy_reg <= div_busy_next;
            div_mul_reg  <= div_mul_next;
            cnt_reg      <= cnt_next;
            rd_reg       <= rd_next;
            work_reg     <= work_next;
            m_valid_reg  <= m_valid_next;
        end
        hex_reg     <= hex_next;
        hex_pos_reg <= hex_pos_next;
        prod_reg    <= prod_next;
        m_char_reg  <= m_char_next;
        m_last_reg  <= m_last_next;
    end

    // base-11 remainders, least significant digit at entry zero
    always_ff @(posedge aclk) begin
        if (store_we) begin
            store_mem[cnt_reg] <= rem;
        end
    end

endmodule

@@ rtl/hab_checker.sv @@
// port-level checks for the hex and base-11 line formatter, bound to the top level
module hab_checker (
    input logic                            aclk,
    input logic                            aresetn,
    input logic                            s_tvalid,
    input logic                            s_tready,
    input logic [hab_pkg::S_TDATA_W-1:0]   s_tdata,   // value[30:0], zero pad
    input logic                            m_tvalid,
    input logic                            m_tready,
    input logic [hab_pkg::M_TDATA_W-1:0]   m_tdata,   // char_code[6:0], zero pad
    input logic                            m_tlast
);
    import hab_pkg::*;

    logic [CHAR_W-1:0] out_char;
    assign out_char = m_tdata[CHAR_W-1:0];

    // a value keeps the block busy for at least the next cycle
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken again right after a beat");

    // the line ends with a newline and only there
    a_last_is_newline: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tlast |-> out_char == ASCII_NL)
        else $error("last beat is not a newline");

    a_newline_is_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tlast |-> out_char != ASCII_NL)
        else $error("newline inside a line");

    // stalled output beat holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("output beat changed under stall");

endmodule

bind hex_and_base11_formatter hab_checker u_hab_checker (.*);
